// ===== hw/rtl/u8sd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants of the byte-serial UTF-8 stream decoder: byte
// class masks, sequence lengths and the job record passed front to back.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned BYTE_W = 8;

    // byte classes
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] END_BYTE   = 8'h00;

    // sequence lengths
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_2    = 3'd2;
    localparam logic [2:0] SEQ_3    = 3'd3;
    localparam logic [2:0] SEQ_4    = 3'd4;

    // one job: up to four results caused by one input byte
    // entry 0 is first_cp, entries 1 to 3 are raw bytes from tail_bytes
    typedef struct packed {
        logic [CP_W-1:0]           first_cp;
        logic [2:0][BYTE_W-1:0]    tail_bytes;
        logic [3:0]                raw;
        logic [1:0]                last_idx;
        logic                      ends;
    } t_job;

endpackage
`default_nettype wire

// ===== hw/rtl/u8sd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_front
// Accepts text bytes, tracks the pending sequence and turns each byte into
// a job listing the results it causes.
// ----------------------------------------------------------------------------
module u8sd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire logic [7:0]     i_text_byte,
    input  wire logic           i_final_byte,
    input  wire logic           i_q_full,
    output logic                o_full,
    output logic                o_job_push,
    output u8sd_pkg::t_job      o_job
);

    logic [1:0] r_held_count, n_held_count;
    logic [2:0] r_seq_len, n_seq_len;
    logic [7:0] r_lead, n_lead;
    logic [7:0] r_cont0, n_cont0;
    logic [7:0] r_cont1, n_cont1;

    logic       accept;
    logic       is_cont;
    logic       hit_cont;
    logic       complete;
    logic       ends;
    logic       byte_emit;
    logic       job_valid;
    logic [2:0] fresh_len;
    logic [20:0] assembled;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    // byte classification
    always_comb begin
        is_cont  = (i_text_byte & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_CODE;
        ends     = i_final_byte || (i_text_byte == u8sd_pkg::END_BYTE);
        hit_cont = (r_held_count != 2'd0) && is_cont;
        complete = hit_cont && (({1'b0, r_held_count} + 3'd1) >= r_seq_len);
        if ((i_text_byte & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_CODE) begin
            fresh_len = u8sd_pkg::SEQ_2;
        end else if ((i_text_byte & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_CODE) begin
            fresh_len = u8sd_pkg::SEQ_3;
        end else if ((i_text_byte & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_CODE) begin
            fresh_len = u8sd_pkg::SEQ_4;
        end else begin
            fresh_len = u8sd_pkg::SEQ_NONE;
        end
    end

    // code point assembly from held bytes and the closing continuation
    always_comb begin
        unique case (r_seq_len)
            u8sd_pkg::SEQ_2: assembled = {10'd0, r_lead[4:0], i_text_byte[5:0]};
            u8sd_pkg::SEQ_3: assembled = {5'd0, r_lead[3:0], r_cont0[5:0],
                                          i_text_byte[5:0]};
            default:         assembled = {r_lead[2:0], r_cont0[5:0], r_cont1[5:0],
                                          i_text_byte[5:0]};
        endcase
    end

    // job building: held bytes first, then the current byte if it is emitted
    always_comb begin
        if (hit_cont) begin
            byte_emit = ends;
        end else begin
            byte_emit = (i_text_byte != u8sd_pkg::END_BYTE)
                     && (!i_text_byte[7] || (fresh_len == u8sd_pkg::SEQ_NONE) || ends);
        end
        job_valid = complete
                 || ((!hit_cont || ends) && ((r_held_count != 2'd0) || byte_emit));

        o_job.ends          = ends;
        o_job.tail_bytes[0] = (r_held_count == 2'd1) ? i_text_byte : r_cont0;
        o_job.tail_bytes[1] = (r_held_count == 2'd2) ? i_text_byte : r_cont1;
        o_job.tail_bytes[2] = i_text_byte;
        if (complete) begin
            o_job.first_cp = assembled;
            o_job.raw      = 4'b0000;
            o_job.last_idx = 2'd0;
        end else begin
            o_job.first_cp = (r_held_count != 2'd0) ? {13'd0, r_lead}
                                                    : {13'd0, i_text_byte};
            o_job.raw[0]   = (r_held_count > 2'd0) ? 1'b1 : i_text_byte[7];
            o_job.raw[1]   = (r_held_count > 2'd1) ? 1'b1 : i_text_byte[7];
            o_job.raw[2]   = (r_held_count > 2'd2) ? 1'b1 : i_text_byte[7];
            o_job.raw[3]   = i_text_byte[7];
            o_job.last_idx = r_held_count + {1'b0, byte_emit} - 2'd1;
        end
        o_job_push = accept && job_valid;
    end

    // next sequence state
    always_comb begin
        n_held_count = r_held_count;
        n_seq_len    = r_seq_len;
        n_lead       = r_lead;
        n_cont0      = r_cont0;
        n_cont1      = r_cont1;
        if (accept) begin
            if (complete) begin
                n_held_count = 2'd0;
                n_seq_len    = u8sd_pkg::SEQ_NONE;
            end else if (hit_cont) begin
                if (r_held_count == 2'd1) begin
                    n_cont0 = i_text_byte;
                end else begin
                    n_cont1 = i_text_byte;
                end
                n_held_count = r_held_count + 2'd1;
                if (ends) begin
                    n_held_count = 2'd0;
                    n_seq_len    = u8sd_pkg::SEQ_NONE;
                end
            end else begin
                n_held_count = 2'd0;
                n_seq_len    = u8sd_pkg::SEQ_NONE;
                if ((fresh_len != u8sd_pkg::SEQ_NONE) && !ends) begin
                    n_lead       = i_text_byte;
                    n_held_count = 2'd1;
                    n_seq_len    = fresh_len;
                end
            end
        end
    end

    // sequence control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_seq_len    <= u8sd_pkg::SEQ_NONE;
        end else begin
            r_held_count <= n_held_count;
            r_seq_len    <= n_seq_len;
        end
    end

    // held bytes
    always_ff @(posedge i_clk) begin
        r_lead  <= n_lead;
        r_cont0 <= n_cont0;
        r_cont1 <= n_cont1;
    end

    // pending bytes never reach the sequence length
    a_held_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_count != 2'd0) |-> ({1'b0, r_held_count} < r_seq_len))
        else $error("held byte count not below sequence length");

    // idle exactly when no length is recorded
    a_idle_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_count == 2'd0) == (r_seq_len == u8sd_pkg::SEQ_NONE))
        else $error("sequence length out of step with held count");

endmodule
`default_nettype wire

// ===== hw/rtl/u8sd_jobq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_jobq
// Two-entry job queue between the classifying front end and the result
// sequencer.
// ----------------------------------------------------------------------------
module u8sd_jobq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  u8sd_pkg::t_job      i_job,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output u8sd_pkg::t_job      o_job
);

    u8sd_pkg::t_job r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // pointers agree with fill level
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == 2'd0) || (r_count == 2'd2)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill level");

endmodule
`default_nettype wire

// ===== hw/rtl/u8sd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_back
// Result sequencer: walks the entries of each job, one result per cycle while the
// output register is free or being popped, into an output register read through the empty/pop side.
// ----------------------------------------------------------------------------
module u8sd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  u8sd_pkg::t_job      i_job,
    output logic                o_job_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic [20:0]         o_code_point,
    output logic                o_raw_fallback,
    output logic                o_run_last,
    output logic                o_text_done
);

    u8sd_pkg::t_job r_job;
    logic           r_busy;
    logic [1:0]     r_idx;
    logic           r_out_valid;
    logic [20:0]    r_code_point;
    logic           r_raw_fallback;
    logic           r_run_last;
    logic           r_text_done;

    u8sd_pkg::t_job src;
    logic [1:0]     cur_idx;
    logic [1:0]     tail_idx;
    logic           out_free;
    logic           emit;
    logic           is_last;
    logic [20:0]    entry_cp;

    // entry selection: running job, else queue head
    always_comb begin
        src      = r_busy ? r_job : i_job;
        cur_idx  = r_busy ? r_idx : 2'd0;
        tail_idx = cur_idx - 2'd1;
        out_free = !r_out_valid || i_pop;
        emit     = (r_busy || i_job_valid) && out_free;
        is_last  = cur_idx == src.last_idx;
        entry_cp = (cur_idx == 2'd0) ? src.first_cp
                                     : {13'd0, src.tail_bytes[tail_idx]};
        o_job_pop = emit && !r_busy;
    end

    // sequencer and output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_busy      <= !is_last;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // job copy, entry index and result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (!r_busy) begin
                r_job <= i_job;
            end
            r_idx          <= cur_idx + 2'd1;
            r_code_point   <= entry_cp;
            r_raw_fallback <= src.raw[cur_idx];
            r_run_last     <= is_last;
            r_text_done    <= is_last && src.ends;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_code_point   = r_code_point;
    assign o_raw_fallback = r_raw_fallback;
    assign o_run_last     = r_run_last;
    assign o_text_done    = r_text_done;

    // a running job always has an entry left
    a_busy_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_idx != 2'd0) && (r_idx <= r_job.last_idx)))
        else $error("sequencer index outside running job");

    // end of text is only flagged on the last result of a byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_text_done) |-> r_run_last)
        else $error("text end flagged before last result");

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder.sv =====
// Data path: a byte's job is registered in the job queue, and each result in the output register.
// Throughput: one byte per cycle while each byte yields at most one result and results are
// popped without stalls; a byte that yields n results (n up to 4) holds the result sequencer
// until its last result is out, with two jobs of slack in the queue in front of it.
// Reset: synchronous, active low; clears the pending sequence, the job queue and the output stage.
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder: front end classifies bytes into jobs, a short
// queue decouples it from the sequencer that emits code points.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_final_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [20:0]      o_code_point,
    output logic             o_raw_fallback,
    output logic             o_run_last,
    output logic             o_text_done
);

    u8sd_pkg::t_job front_job;
    u8sd_pkg::t_job head_job;
    logic           front_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    // byte classification and sequence state
    u8sd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .i_q_full     (q_full),
        .o_full       (full),
        .o_job_push   (front_push),
        .o_job        (front_job)
    );

    // job queue
    u8sd_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (head_job)
    );

    // result sequencer and output register
    u8sd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (head_job),
        .o_job_pop      (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_code_point   (o_code_point),
        .o_raw_fallback (o_raw_fallback),
        .o_run_last     (o_run_last),
        .o_text_done    (o_text_done)
    );

endmodule
`default_nettype wire

// ===== sim/utf8_stream_decoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_test
// Self-checking bench for the byte-serial UTF-8 decoder. Bytes go in through
// a push/full queue port and code points come out through an empty/pop port.
// A behavioural decoder predicts every code point, and each result transfer
// is compared against the oldest prediction. Directed cases cover extremes,
// broken sequences and end of text. Random text follows, under random idling,
// long output stalls and a full drain pause.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_test;

    localparam int CP_W           = u8sd_pkg::CP_W;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int LONG_HOLD      = 64;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            raw_fallback;
        logic            run_last;
        logic            text_done;
    } t_cp_result;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              push         = 1'b0;
    logic              full;
    logic [7:0]        i_text_byte  = 8'h00;
    logic              i_final_byte = 1'b0;
    logic              empty;
    logic              pop          = 1'b0;
    logic [CP_W-1:0]   o_code_point;
    logic              o_raw_fallback;
    logic              o_run_last;
    logic              o_text_done;

    // shadow decoder state
    logic [7:0]        dec_lead     = 8'h00;
    logic [7:0]        dec_cont [2] = '{8'h00, 8'h00};
    logic [1:0]        dec_count    = 2'd0;
    logic [2:0]        dec_len      = u8sd_pkg::SEQ_NONE;

    // predicted code points, oldest first
    t_cp_result        pending_cps[$];

    bit                tx_idle_on    = 1'b1;
    bit                rx_idle_on    = 1'b1;
    bit                tx_offering   = 1'b0;
    int                rx_hold_cycles = 0;
    int                error_count   = 0;
    int                bytes_sent    = 0;
    int                cps_checked   = 0;
    int                raw_seen      = 0;
    int                texts_ended   = 0;
    int                idle_cycles   = 0;

    utf8_stream_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_text_byte    (i_text_byte),
        .i_final_byte   (i_final_byte),
        .empty          (empty),
        .pop            (pop),
        .o_code_point   (o_code_point),
        .o_raw_fallback (o_raw_fallback),
        .o_run_last     (o_run_last),
        .o_text_done    (o_text_done)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic void emit_cp(input logic [CP_W-1:0] cp, input logic raw);
        pending_cps.push_back('{cp, raw, 1'b0, 1'b0});
    endfunction

    // every held byte goes out raw, then back to idle
    function automatic void release_held();
        if (dec_count != 2'd0) begin
            emit_cp(CP_W'(dec_lead), 1'b1);
            for (int i = 1; i < dec_count; i++)
                emit_cp(CP_W'(dec_cont[i-1]), 1'b1);
        end
        dec_count = 2'd0;
        dec_len   = u8sd_pkg::SEQ_NONE;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic            ends;
        logic [2:0]      new_len;
        logic [CP_W-1:0] cp;
        int              n_prior;
        ends    = fin || (b == u8sd_pkg::END_BYTE);
        n_prior = pending_cps.size();
        new_len = u8sd_pkg::SEQ_NONE;
        if (dec_count != 2'd0 && (b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_CODE) begin
            // continuation of the pending sequence
            if (3'(dec_count) + 3'd1 >= dec_len) begin
                case (dec_len)
                    u8sd_pkg::SEQ_2: cp = CP_W'({dec_lead[4:0], b[5:0]});
                    u8sd_pkg::SEQ_3: cp = CP_W'({dec_lead[3:0], dec_cont[0][5:0], b[5:0]});
                    default: cp = {dec_lead[2:0], dec_cont[0][5:0], dec_cont[1][5:0], b[5:0]};
                endcase
                emit_cp(cp, 1'b0);
                dec_count = 2'd0;
                dec_len   = u8sd_pkg::SEQ_NONE;
            end else begin
                dec_cont[1'(dec_count - 2'd1)] = b;
                dec_count++;
            end
        end else begin
            // broken sequence: release, then treat the byte as fresh
            release_held();
            if (b != u8sd_pkg::END_BYTE) begin
                if (!b[7])
                    emit_cp(CP_W'(b), 1'b0);
                else begin
                    if ((b & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_CODE)
                        new_len = u8sd_pkg::SEQ_2;
                    else if ((b & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_CODE)
                        new_len = u8sd_pkg::SEQ_3;
                    else if ((b & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_CODE)
                        new_len = u8sd_pkg::SEQ_4;
                    if (new_len == u8sd_pkg::SEQ_NONE)
                        emit_cp(CP_W'(b), 1'b1);
                    else begin
                        dec_lead  = b;
                        dec_count = 2'd1;
                        dec_len   = new_len;
                    end
                end
            end
        end
        if (ends)
            release_held();
        // flag the last code point of this byte
        if (pending_cps.size() > n_prior) begin
            pending_cps[pending_cps.size()-1].run_last  = 1'b1;
            pending_cps[pending_cps.size()-1].text_done = ends;
        end
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            if (tx_offering)
                push <= 1'b0;
            tx_offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_text_byte  <= b;
        i_final_byte <= fin;
        tx_offering  = 1'b1;
        do @(posedge i_clk); while (full);
        decode_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic stop_sending();
        if (tx_offering)
            push <= 1'b0;
        tx_offering = 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_cps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random text: mostly well-formed characters, some truncated, some noise
    task automatic send_text(input int n_bytes);
        logic [7:0] chars[$];
        int         sent;
        int         kind;
        int         len;
        int         keep;
        sent = 0;
        while (sent < n_bytes) begin
            chars.delete();
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                len = $urandom_range(1, 4);
                case (len)
                    1: chars.push_back(8'($urandom_range(1, 127)));
                    2: chars.push_back({3'b110, 5'($urandom)});
                    3: chars.push_back({4'b1110, 4'($urandom)});
                    default: chars.push_back({5'b11110, 3'($urandom)});
                endcase
                for (int i = 1; i < len; i++)
                    chars.push_back({2'b10, 6'($urandom)});
                // truncate some sequences so the next byte breaks them
                if (kind >= 65 && len > 1) begin
                    keep = $urandom_range(1, len - 1);
                    while (chars.size() > keep)
                        void'(chars.pop_back());
                end
            end else if (kind < 92)
                chars.push_back(8'($urandom_range(0, 255)));
            else if (kind < 97)
                chars.push_back({2'b10, 6'($urandom)});
            else
                chars.push_back(u8sd_pkg::END_BYTE);
            foreach (chars[i]) begin
                send_byte(chars[i], $urandom_range(0, 15) == 0);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    function automatic void check_result();
        t_cp_result want;
        cps_checked++;
        if (o_raw_fallback)
            raw_seen++;
        if (o_text_done)
            texts_ended++;
        if (pending_cps.size() == 0) begin
            $error("code point %h transferred with nothing expected", o_code_point);
            error_count++;
            return;
        end
        want = pending_cps.pop_front();
        if (o_code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, o_code_point);
            error_count++;
        end
        if (o_raw_fallback !== want.raw_fallback) begin
            $error("raw_fallback: expected %b, got %b", want.raw_fallback, o_raw_fallback);
            error_count++;
        end
        if (o_run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, o_run_last);
            error_count++;
        end
        if (o_text_done !== want.text_done) begin
            $error("text_done: expected %b, got %b", want.text_done, o_text_done);
            error_count++;
        end
    endfunction

    // result sink with random idling and requested long holds
    initial begin : result_sink
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                pop <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle_on ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            check_result();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // ascii limits
    task automatic test_single_bytes();
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    // smallest and largest two-byte values, a three-byte sequence and the largest four-byte value
    task automatic test_sequences();
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    // stray bytes and a four-byte sequence broken by ascii
    task automatic test_broken_sequences();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    // zero byte mid-sequence, empty end, final flag on a lead byte
    task automatic test_text_end();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(u8sd_pkg::END_BYTE, 1'b0);
        send_byte(u8sd_pkg::END_BYTE, 1'b0);
        send_byte(8'hC3, 1'b1);
    endtask

    // back-to-back transfers on both sides
    task automatic test_streaming();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_text(40);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // long output stall while bytes keep coming, so the input backs up
    task automatic test_output_stall();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = LONG_HOLD;
        send_text(30);
        tx_idle_on     = 1'b1;
    endtask

    // sender waits for every result before carrying on
    task automatic test_sender_pause();
        stop_sending();
        wait_for_drain();
        send_text(20);
    endtask

    task automatic test_random_text();
        send_text(120);
    endtask

    initial begin
        apply_reset();
        test_single_bytes();
        test_sequences();
        test_broken_sequences();
        test_text_end();
        test_streaming();
        test_output_stall();
        test_sender_pause();
        test_random_text();
        stop_sending();
        wait_for_drain();
        $display("sent %0d bytes: checked %0d code points, %0d raw, %0d text ends",
                 bytes_sent, cps_checked, raw_seen, texts_ended);
        $display("covered extremes, broken and stray bytes, end of text, stalls and drains");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
